// File: src/rts_pkg.sv
// Shared types, constants and byte-packing helpers for the RGBA8 tile swizzle unit.
package rts_pkg;

  // Tile geometry and default sizes
  localparam int TILE           = 4;
  localparam int LANE_W         = $clog2(TILE);
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int HEIGHT_LIMIT   = 1024;
  localparam int ROW_W          = $clog2(HEIGHT_LIMIT);
  localparam int FIFO_DEPTH_DEF = 16;

  // Field widths
  localparam int PIX_W  = 32;
  localparam int WORD_W = 64;
  localparam int CFG_W  = 11;
  localparam int SIZE_W = 13;

  // APB port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  // Register map, one word per register
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // One result word with its markers
  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic              tile_last;
    logic              frame_last;
  } word_t;

  // Clamp to limit, round down to a tile multiple, at least one tile
  function automatic logic [SIZE_W-1:0] size_fix(input logic [CFG_W-1:0]  v,
                                                 input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] t;
    t = {{(SIZE_W-CFG_W){1'b0}}, v};
    if (t > limit) t = limit;
    t[LANE_W-1:0] = '0;
    if (t < SIZE_W'(TILE)) t = SIZE_W'(TILE);
    return t;
  endfunction

  // Tile row as alpha/red pairs, leftmost pixel in the top bits
  function automatic logic [WORD_W-1:0] ar_pack(input logic [TILE*PIX_W-1:0] row);
    logic [WORD_W-1:0] w;
    logic [PIX_W-1:0]  p;
    w = '0;
    for (int c = 0; c < TILE; c++) begin
      p = row[c*PIX_W +: PIX_W];
      w[WORD_W-1-16*c -: 16] = {p[7:0], p[31:24]};
    end
    return w;
  endfunction

  // Tile row as green/blue pairs
  function automatic logic [WORD_W-1:0] gb_pack(input logic [TILE*PIX_W-1:0] row);
    logic [WORD_W-1:0] w;
    logic [PIX_W-1:0]  p;
    w = '0;
    for (int c = 0; c < TILE; c++) begin
      p = row[c*PIX_W +: PIX_W];
      w[WORD_W-1-16*c -: 16] = {p[23:16], p[15:8]};
    end
    return w;
  endfunction

endpackage

// File: src/rts_chan_if.sv
// Valid/ready channel interfaces for pixels in and tile words out.
interface rts_pix_if;
  logic                       valid;
  logic                       ready;
  logic [rts_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface rts_word_if;
  logic                       valid;
  logic                       ready;
  logic [rts_pkg::WORD_W-1:0] out_word;
  logic                       tile_last;
  logic                       frame_last;

  modport source (output valid, output out_word, output tile_last, output frame_last,
                  input ready);
  modport sink   (input valid, input out_word, input tile_last, input frame_last,
                  output ready);
endinterface

// File: src/rts_line_store.sv
// Four-row line store: one pixel lane written per cycle, a full tile row read per cycle.
module rts_line_store #(
  parameter  int DEPTH = rts_pkg::MAX_WIDTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [AW-1:0]                             waddr,
  input  logic [rts_pkg::LANE_W-1:0]                wlane,
  input  logic [rts_pkg::PIX_W-1:0]                 wdata,
  input  logic                                      re,
  input  logic [AW-1:0]                             raddr,
  output logic [rts_pkg::TILE*rts_pkg::PIX_W-1:0]   rdata
);

  logic [rts_pkg::TILE*rts_pkg::PIX_W-1:0] mem [DEPTH];

  // Lane write and registered row read; a same-edge read sees the old entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][wlane*rts_pkg::PIX_W +: rts_pkg::PIX_W] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/rts_word_fifo.sv
// Output queue of tile words that parts the tile reader from the receiver.
module rts_word_fifo #(
  parameter  int DEPTH = rts_pkg::FIFO_DEPTH_DEF,
  localparam int PW    = $clog2(DEPTH),
  localparam int CNTW  = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rts_pkg::word_t       push_word,
  rts_word_if.source           src
);

  rts_pkg::word_t  q_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            pop;
  rts_pkg::word_t  head;

  assign pop  = src.valid && src.ready;
  assign head = q_r[rd_ptr_r];

  // Head of the queue drives the channel
  assign src.valid      = (cnt_r != '0);
  assign src.out_word   = head.out_word;
  assign src.tile_last  = head.tile_last;
  assign src.frame_last = head.frame_last;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_word;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_r + (push ? CNTW'(1) : '0) - (pop ? CNTW'(1) : '0);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < CNTW'(DEPTH))
    else $error("tile word queue overflow");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(DEPTH))
    else $error("tile word queue level out of range");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push && cnt_r == '0 |=> src.valid)
    else $error("pushed word not presented");

endmodule

// File: src/rgba8_tile_swizzle_unit.sv
// Top level: raster RGBA8 pixels in, 4x4 split-layout tile words out, APB registers.
//
// in_chan carries one 32-bit pixel per item in raster order (R 31:24, G 23:16,
// B 15:8, A 7:0). Each pixel is written to a four-row line store at once. The
// pixel that closes a 4x4 tile starts the tile reader, which reads the tile's
// four rows and queues eight 64-bit words on out_chan: four alpha/red rows,
// then four green/blue rows. tile_last marks word eight, frame_last word eight
// of the frame's last tile.
// After the closing pixel, each row read is registered and a push stage then
// writes each word into the queue; the eight words are pushed one per cycle.
// Throughput: one pixel per cycle, except that a tile read starts only when the
// reader is idle or on its last step, as the eight words share the single
// 64-bit output port; a closing pixel waits meanwhile.
// Stalls: words wait in a 16-entry queue. A closing pixel is held off
// (in_chan.ready low) until the reader can start and the queue has room
// reserved for all eight words; other pixels keep flowing.
// Reset: counters return to the frame start, width 640 and height 480. The line
// store is not cleared; no tile reads an entry before it is written.
// Any register write restarts the frame.
module rgba8_tile_swizzle_unit #(
  parameter int MAX_WIDTH  = rts_pkg::MAX_WIDTH_DEF,
  parameter int FIFO_DEPTH = rts_pkg::FIFO_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rts_pix_if.sink                     in_chan,
  rts_word_if.source                  out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rts_pkg::APB_AW-1:0]  paddr,
  input  logic [rts_pkg::APB_DW-1:0]  pwdata,
  output logic [rts_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int GRP         = MAX_WIDTH / rts_pkg::TILE;
  localparam int STORE_DEPTH = rts_pkg::TILE * GRP;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CW          = $clog2(MAX_WIDTH);
  localparam int GW          = (GRP > 1) ? $clog2(GRP) : 1;
  localparam int NWORDS      = 2 * rts_pkg::TILE;
  localparam int SW          = $clog2(NWORDS);
  localparam int RESW        = $clog2(FIFO_DEPTH + 1);
  localparam int LW          = rts_pkg::LANE_W;
  localparam logic [SW-1:0] STEP_LAST = SW'(NWORDS - 1);

  // Configuration and frame position
  logic [rts_pkg::CFG_W-1:0] img_w_r;
  logic [rts_pkg::CFG_W-1:0] img_h_r;
  logic [CW-1:0]             wl_r;
  logic [rts_pkg::ROW_W-1:0] hl_r;
  logic [CW-1:0]             col_r;
  logic [CW-1:0]             col_nxt;
  logic [rts_pkg::ROW_W-1:0] row_r;
  logic [rts_pkg::ROW_W-1:0] row_nxt;
  logic                      cfg_wr;
  rts_pkg::reg_idx_t         cfg_idx;

  // Tile reader and output push stage
  logic                  busy_r;
  logic [SW-1:0]         step_r;
  logic [GW-1:0]         grp_r;
  logic                  fe_r;
  logic                  pv_r;
  logic [SW-1:0]         ps_r;
  logic                  pfe_r;
  logic [RESW-1:0]       res_r;
  logic [RESW-1:0]       res_nxt;
  logic [rts_pkg::WORD_W-1:0] gb_r [rts_pkg::TILE];

  logic                  tile_cmp;
  logic                  frame_cmp;
  logic                  can_start;
  logic                  accept;
  logic                  start;
  logic                  pop;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic                  re;
  logic [rts_pkg::TILE*rts_pkg::PIX_W-1:0] rd_row;
  rts_pkg::word_t        push_word;

  // APB decode
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = rts_pkg::reg_idx_t'(paddr[rts_pkg::APB_AW-1]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      rts_pkg::REG_IMAGE_WIDTH:
        prdata = {{(rts_pkg::APB_DW-rts_pkg::CFG_W){1'b0}}, img_w_r};
      rts_pkg::REG_IMAGE_HEIGHT:
        prdata = {{(rts_pkg::APB_DW-rts_pkg::CFG_W){1'b0}}, img_h_r};
      default:
        prdata = '0;
    endcase
  end

  // Next raster position
  always_comb begin
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (col_r == wl_r) begin
      col_nxt = '0;
      row_nxt = (row_r == hl_r) ? '0 : row_r + rts_pkg::ROW_W'(1);
    end
  end

  // Closing pixel of a tile needs the reader and queue room for eight words
  assign tile_cmp  = (col_r[LW-1:0] == LW'(rts_pkg::TILE - 1)) &&
                     (row_r[LW-1:0] == LW'(rts_pkg::TILE - 1));
  assign frame_cmp = (col_r == wl_r) && (row_r == hl_r);
  assign can_start = (!busy_r || step_r == STEP_LAST) &&
                     (res_r <= RESW'(FIFO_DEPTH - NWORDS));
  assign in_chan.ready = !tile_cmp || can_start;
  assign accept    = in_chan.valid && in_chan.ready;
  assign start     = accept && tile_cmp;
  assign pop       = out_chan.valid && out_chan.ready;

  // Registers and frame counters; a write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= rts_pkg::WIDTH_RESET;
      img_h_r <= rts_pkg::HEIGHT_RESET;
      wl_r    <= CW'(rts_pkg::size_fix(rts_pkg::WIDTH_RESET,
                 rts_pkg::SIZE_W'(MAX_WIDTH)) - rts_pkg::SIZE_W'(1));
      hl_r    <= rts_pkg::ROW_W'(rts_pkg::size_fix(rts_pkg::HEIGHT_RESET,
                 rts_pkg::SIZE_W'(rts_pkg::HEIGHT_LIMIT)) - rts_pkg::SIZE_W'(1));
      col_r   <= '0;
      row_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rts_pkg::REG_IMAGE_WIDTH: begin
          img_w_r <= pwdata[rts_pkg::CFG_W-1:0];
          wl_r    <= CW'(rts_pkg::size_fix(pwdata[rts_pkg::CFG_W-1:0],
                     rts_pkg::SIZE_W'(MAX_WIDTH)) - rts_pkg::SIZE_W'(1));
        end
        rts_pkg::REG_IMAGE_HEIGHT: begin
          img_h_r <= pwdata[rts_pkg::CFG_W-1:0];
          hl_r    <= rts_pkg::ROW_W'(rts_pkg::size_fix(pwdata[rts_pkg::CFG_W-1:0],
                     rts_pkg::SIZE_W'(rts_pkg::HEIGHT_LIMIT)) - rts_pkg::SIZE_W'(1));
        end
        default: begin
          img_w_r <= img_w_r;
        end
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Store addressing: row slot times row pitch plus column group
  assign waddr = AW'(row_r[LW-1:0]) * AW'(GRP) + AW'(col_r >> LW);
  assign raddr = AW'(step_r[LW-1:0]) * AW'(GRP) + AW'(grp_r);
  assign re    = busy_r && !step_r[SW-1];

  rts_line_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wlane (col_r[LW-1:0]),
    .wdata (in_chan.pixel),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_row)
  );

  // Reader sequence: rows read in steps 0-3, each word pushed in the cycle after its step
  assign res_nxt = res_r + (start ? RESW'(NWORDS) : '0) - (pop ? RESW'(1) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      pv_r   <= 1'b0;
      res_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        busy_r <= (step_r != STEP_LAST);
        step_r <= step_r + SW'(1);
      end
      pv_r  <= busy_r;
      res_r <= res_nxt;
    end
  end

  // Tile context travels alongside the steps
  always_ff @(posedge clk) begin
    if (start) begin
      grp_r <= GW'(col_r >> LW);
      fe_r  <= frame_cmp;
    end
    ps_r  <= step_r;
    pfe_r <= fe_r;
  end

  // Green/blue rows wait until the alpha/red rows are out
  always_ff @(posedge clk) begin
    if (pv_r && !ps_r[SW-1]) begin
      gb_r[ps_r[LW-1:0]] <= rts_pkg::gb_pack(rd_row);
    end
  end

  always_comb begin
    push_word.out_word   = ps_r[SW-1] ? gb_r[ps_r[LW-1:0]] : rts_pkg::ar_pack(rd_row);
    push_word.tile_last  = (ps_r == STEP_LAST);
    push_word.frame_last = (ps_r == STEP_LAST) && pfe_r;
  end

  rts_word_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pv_r),
    .push_word (push_word),
    .src       (out_chan)
  );

  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_r <= RESW'(FIFO_DEPTH))
    else $error("word reservation exceeds queue depth");

  a_start_room: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> res_r <= RESW'(FIFO_DEPTH - NWORDS))
    else $error("tile started without queue room");

  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && step_r == '0)
    else $error("tile reader did not start");

endmodule

// File: bench/rgba8_tile_swizzle_unit_test.sv
// Self-checking bench for the RGBA8 4x4 tile swizzle unit: predicts tile words from raster pixels.
module rgba8_tile_swizzle_unit_test;
  import rts_pkg::*;

  localparam int MAX_W         = MAX_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RESET_PIXELS  = 64;
  localparam int TALL_PIXELS   = 64;
  localparam int WIDE_PIXELS   = 32;
  localparam int RANDOM_PIXELS = 170;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  rts_pix_if  pix_chan ();
  rts_word_if word_chan ();

  rgba8_tile_swizzle_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pix_chan),
    .out_chan (word_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Predictor state: line store, raster position and raw register values
  logic [PIX_W-1:0] line_buf [TILE][MAX_W];
  int               pix_col;
  int               pix_row;
  logic [CFG_W-1:0] frame_w_raw;
  logic [CFG_W-1:0] frame_h_raw;

  logic [PIX_W-1:0] pending_pixels [$];
  word_t            tile_words [$];
  int               mismatch_count;

  // Pacing knobs, changed per phase
  int               max_gap;
  int               max_burst;
  logic [15:0]      stall_mask;

  // Clamp, round down to a tile multiple, at least one tile
  function automatic int fit_size(input logic [CFG_W-1:0] raw, input int limit);
    int t;
    t = raw;
    if (t > limit) t = limit;
    t = t - (t % TILE);
    if (t < TILE) t = TILE;
    return t;
  endfunction

  // Store one pixel; on a tile's closing pixel queue its eight words
  function automatic void swizzle_pixel(input logic [PIX_W-1:0] px);
    int               w;
    int               h;
    int               col;
    int               row;
    int               base;
    logic [WORD_W-1:0] acc;
    logic [PIX_W-1:0]  p;
    word_t             wd;
    w   = fit_size(frame_w_raw, MAX_W);
    h   = fit_size(frame_h_raw, HEIGHT_LIMIT);
    col = pix_col;
    row = pix_row;
    if (col >= w) col = 0;
    if (row >= h) row = 0;
    line_buf[row % TILE][col] = px;
    if (col % TILE == TILE - 1 && row % TILE == TILE - 1) begin
      base = col - (TILE - 1);
      // rows 0..3 as alpha/red, then rows 0..3 as green/blue
      for (int r = 0; r < 2 * TILE; r++) begin
        acc = '0;
        for (int c = 0; c < TILE; c++) begin
          p = line_buf[r % TILE][base + c];
          if (r < TILE) acc = {acc[WORD_W-17:0], p[7:0], p[31:24]};
          else acc = {acc[WORD_W-17:0], p[23:16], p[15:8]};
        end
        wd.out_word   = acc;
        wd.tile_last  = (r == 2 * TILE - 1);
        wd.frame_last = wd.tile_last && (col == w - 1) && (row == h - 1);
        tile_words.push_back(wd);
      end
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    pix_col = col;
    pix_row = row;
  endfunction

  // Mix of corner values and fully random pixels
  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return PIX_W'(32'hFF) << (8 * $urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // Randomize sender bursts/gaps and the receiver stall pattern
  function automatic void shuffle_pacing();
    max_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    max_burst = $urandom_range(1, 16);
    // bit 0 stays clear so the receiver never stalls for good
    stall_mask = ($urandom_range(0, 3) == 0) ? 16'h0000 : (16'($urandom) & 16'hFFFE);
  endfunction

  // APB write: setup cycle, then access cycle; counters restart on any write
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  frame_w_raw = value[CFG_W-1:0];
      REG_IMAGE_HEIGHT: frame_h_raw = value[CFG_W-1:0];
    endcase
    pix_col = 0;
    pix_row = 0;
  endtask

  // Wait for all pixels taken and all words seen, then let the pipe drain
  task automatic settle();
    do @(posedge clk);
    while (pending_pixels.size() != 0 || pix_chan.valid || tile_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel driver: bursts of random length with random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      pix_chan.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (pix_chan.valid && pix_chan.ready) swizzle_pixel(pix_chan.pixel);
      if (!pix_chan.valid || pix_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_chan.valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          pix_chan.valid <= 1'b1;
          pix_chan.pixel <= pending_pixels.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, max_burst);
            gap_left   = $urandom_range(0, max_gap);
          end else begin
            burst_left--;
          end
        end else begin
          pix_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Word receiver: ready follows a rotating stall pattern
  logic [3:0] stall_pos;

  always @(posedge clk) begin
    if (!rst_n) begin
      word_chan.ready <= 1'b0;
      stall_pos <= '0;
    end else begin
      word_chan.ready <= !stall_mask[stall_pos];
      stall_pos <= stall_pos + 1'b1;
    end
  end

  // Word monitor: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    word_t exp_word;
    if (rst_n && word_chan.valid && word_chan.ready) begin
      if (tile_words.size() == 0) begin
        $error("unexpected word %h", word_chan.out_word);
        mismatch_count++;
      end else begin
        exp_word = tile_words.pop_front();
        if (word_chan.out_word !== exp_word.out_word) begin
          $error("out_word: expected %h, got %h", exp_word.out_word, word_chan.out_word);
          mismatch_count++;
        end
        if (word_chan.tile_last !== exp_word.tile_last) begin
          $error("tile_last: expected %b, got %b", exp_word.tile_last, word_chan.tile_last);
          mismatch_count++;
        end
        if (word_chan.frame_last !== exp_word.frame_last) begin
          $error("frame_last: expected %b, got %b", exp_word.frame_last,
                 word_chan.frame_last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  int quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (pix_chan.valid && pix_chan.ready) ||
        (word_chan.valid && word_chan.ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rgba8_tile_swizzle_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    logic [PIX_W-1:0] corner_px [16];
    int               random_sent;
    int               choice;
    int               n;
    int               w;
    int               h;
    corner_px = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h00FF_0000,
                  32'h0000_FF00, 32'h0000_00FF, 32'h0123_4567, 32'h89AB_CDEF,
                  32'h8080_8080, 32'h7F7F_7F7F, 32'hAA55_AA55, 32'h55AA_55AA,
                  32'hFEDC_BA98, 32'h7654_3210, 32'h00FF_00FF, 32'hFF00_FF00};
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    pix_chan.valid  = 1'b0;
    pix_chan.pixel  = '0;
    word_chan.ready = 1'b0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    pix_col         = 0;
    pix_row         = 0;
    frame_w_raw     = WIDTH_RESET;
    frame_h_raw     = HEIGHT_RESET;
    shuffle_pacing();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes: start of the first 640-pixel row, no tile closes yet
    repeat (RESET_PIXELS) pending_pixels.push_back(pick_pixel());
    settle();

    // single-tile frame with corner pixel values
    shuffle_pacing();
    write_reg(REG_IMAGE_WIDTH, 32'd4);
    write_reg(REG_IMAGE_HEIGHT, 32'd4);
    foreach (corner_px[i]) pending_pixels.push_back(corner_px[i]);
    settle();

    // partial frame, then a register write restarts it
    repeat (6) pending_pixels.push_back(pick_pixel());
    settle();

    // width below range with height above range: first tiles of a 4 x 1024 frame
    shuffle_pacing();
    write_reg(REG_IMAGE_WIDTH, 32'hFFFF_F800);
    write_reg(REG_IMAGE_HEIGHT, 32'h0000_07FF);
    repeat (TALL_PIXELS) pending_pixels.push_back(pick_pixel());
    settle();

    // width above range with unaligned height: start of a 1024 x 4 frame
    shuffle_pacing();
    write_reg(REG_IMAGE_WIDTH, 32'h5A5A_5FFF);
    write_reg(REG_IMAGE_HEIGHT, 32'd6);
    repeat (WIDE_PIXELS) pending_pixels.push_back(pick_pixel());
    settle();

    // random sizes, pacing and frame counts
    random_sent = 0;
    while (random_sent < RANDOM_PIXELS) begin
      shuffle_pacing();
      choice = $urandom_range(0, 3);
      if (choice == 1 || choice == 3) begin
        write_reg(REG_IMAGE_WIDTH, ($urandom & 32'hFFFF_F800) |
                  (($urandom_range(0, 3) == 0) ? $urandom_range(0, 19)
                                                : 4 * $urandom_range(1, 4)));
      end
      if (choice == 2 || choice == 3) begin
        write_reg(REG_IMAGE_HEIGHT, ($urandom & 32'hFFFF_F800) |
                  (($urandom_range(0, 3) == 0) ? $urandom_range(0, 11)
                                                : 4 * $urandom_range(1, 2)));
      end
      w = fit_size(frame_w_raw, MAX_W);
      h = fit_size(frame_h_raw, HEIGHT_LIMIT);
      n = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 2) == 0) n += $urandom_range(1, w * h - 1);
      // keep the total near the item budget
      if (random_sent + n > RANDOM_PIXELS) n = RANDOM_PIXELS - random_sent;
      repeat (n) pending_pixels.push_back(pick_pixel());
      random_sent += n;
      settle();
    end

    if (mismatch_count == 0 && tile_words.size() == 0) begin
      $display("rgba8_tile_swizzle_unit test passed");
    end else begin
      $display("rgba8_tile_swizzle_unit test failed");
    end
    $finish;
  end

endmodule
